// ===== rtl/core/assert_macros.svh =====
// assertion helpers, sampled on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rlmts_pkg.sv =====
`timescale 1ns / 1ps

package rlmts_pkg;

	localparam logic [1:0] CH_OFF   = 2'd0;
	localparam logic [1:0] CH_RED   = 2'd1;
	localparam logic [1:0] CH_GREEN = 2'd2;
	localparam logic [1:0] CH_BLUE  = 2'd3;

	localparam logic [2:0] MASK_RED   = 3'h1;
	localparam logic [2:0] MASK_GREEN = 3'h2;
	localparam logic [2:0] MASK_BLUE  = 3'h4;

	localparam logic [7:0] HOLD_DUR = 8'd255;
	localparam int unsigned PHASE_SLOTS = 6;
	localparam int unsigned PATTERN_W = 24;

	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [2:0] COL_OFF    = 3'd0;
	localparam logic [2:0] COL_RED    = 3'd1;
	localparam logic [2:0] COL_GREEN  = 3'd2;
	localparam logic [2:0] COL_BLUE   = 3'd3;
	localparam logic [2:0] COL_YELLOW = 3'd4;
	localparam logic [2:0] COL_PURPLE = 3'd5;
	localparam logic [2:0] COL_CYAN   = 3'd6;

	typedef enum logic [1:0] {
		REG_RED_ON,
		REG_GREEN_ON,
		REG_BLUE_ON,
		REG_GAP_OFF
	} cfg_reg_t;

	typedef struct packed {
		logic       en;
		logic [2:0] color;
	} entry_t;

	function automatic logic [2:0] colour_bits(input logic [2:0] color);
		logic [2:0] b;
		case (color)
			COL_RED:    b = MASK_RED;
			COL_GREEN:  b = MASK_GREEN;
			COL_BLUE:   b = MASK_BLUE;
			COL_YELLOW: b = MASK_RED | MASK_GREEN;
			COL_PURPLE: b = MASK_RED | MASK_BLUE;
			COL_CYAN:   b = MASK_GREEN | MASK_BLUE;
			default:    b = 3'h0;
		endcase
		return b;
	endfunction

	function automatic logic [2:0] chan_bit(input logic [1:0] ch);
		logic [2:0] b;
		case (ch)
			CH_RED:   b = MASK_RED;
			CH_GREEN: b = MASK_GREEN;
			CH_BLUE:  b = MASK_BLUE;
			default:  b = 3'h0;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] countdown(input logic [7:0] dur);
		return (dur != HOLD_DUR && dur != 8'd0) ? 8'(dur - 8'd1) : 8'd0;
	endfunction

endpackage

// ===== rtl/core/rlmts_if.sv =====
`timescale 1ns / 1ps

interface rlmts_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [5:0] led_index;
	logic       led_enable;
	logic [2:0] led_color;

	modport source (output valid, req_type, led_index, led_enable, led_color, input ready);
	modport sink (input valid, req_type, led_index, led_enable, led_color, output ready);
endinterface

interface rlmts_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  channel_select;
	logic [23:0] led_pattern;

	modport source (output valid, channel_select, led_pattern, input ready);
	modport sink (input valid, channel_select, led_pattern, output ready);
endinterface

interface rlmts_cfg_if;
	logic                valid;
	logic                ready;
	rlmts_pkg::cfg_reg_t index;
	logic [7:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rgb_led_multiplex_tick_sequencer.sv =====
`timescale 1ns / 1ps

// Multiplex sequencer for common-cathode RGB LEDs.
// req channel: a write item (req_type 1) stores enable and colour for one LED
// and yields no result; req stays ready after it. A tick item (req_type 0)
// yields one result on rsp: the cathode channel to drive and the 24-bit
// shift pattern for it, then every second tick advances the phase schedule.
// cfg channel: always ready, sets the phase lengths; they apply at the next
// rebuild of the phase list.
// A tick walks the LED table through its single read port, one entry a cycle
// over the first min(WIRED_COUNT, LED_COUNT) entries, then registers the
// result; req is not ready while a tick is in progress. On a mask change a
// schedule step adds a list rebuild (mixed colours) and the first phase load.
// The result register parts rsp from the sequencer: a stalled rsp only holds
// the sequencer when the next result is due and the register is still full.
// Reset clears the LED table at once (per-entry valid flags), the schedule
// state and the registers to their defaults; no clearing pass is needed.

module rgb_led_multiplex_tick_sequencer #(
	parameter int unsigned LED_COUNT = 24,
	parameter int unsigned WIRED_COUNT = 20
) (
	input logic           clk,
	input logic           arst_n,
	rlmts_req_if.sink     req,
	rlmts_rsp_if.source   rsp,
	rlmts_cfg_if.sink     cfg
);

	`include "assert_macros.svh"

	localparam int unsigned SCAN_N = (WIRED_COUNT < LED_COUNT) ? WIRED_COUNT : LED_COUNT;
	localparam int unsigned AW = $clog2(LED_COUNT);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned PW = rlmts_pkg::PATTERN_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT,
		S_ADV,
		S_BUILD,
		S_FINISH
	} state_t;

	state_t state_q;

	logic [7:0] red_on_q, green_on_q, blue_on_q, gap_off_q;

	logic [CW-1:0] scan_cnt_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [PW-1:0] pat_q;
	logic [2:0]    mask_q;

	logic       toggle_q;
	logic [2:0] prev_mask_q;
	logic [2:0] phase_count_q;
	logic [2:0] phase_pos_q;
	logic [7:0] ms_rem_q;
	logic [1:0] cur_ch_q;
	logic [1:0] bld_q;
	logic       gap_pend_q;

	logic [1:0] phase_col_q [rlmts_pkg::PHASE_SLOTS];
	logic [7:0] phase_dur_q [rlmts_pkg::PHASE_SLOTS];

	logic        out_valid_q;
	logic [1:0]  out_ch_q;
	logic [PW-1:0] out_pat_q;

	logic              tick_acc, wr_acc, tbl_we, out_load, out_free;
	rlmts_pkg::entry_t tbl_wentry, tbl_rentry;
	logic [2:0]        ent_bits;
	logic [2:0]        pos_inc, pos_next;
	logic              ph_we;
	logic [2:0]        ph_idx;
	logic [1:0]        ph_col;
	logic [7:0]        ph_dur;
	logic [1:0]        bld_col;
	logic [7:0]        bld_dur;
	logic              mask_single;
	logic [1:0]        single_col;

	// handshakes
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign tick_acc  = req.valid && req.ready && (req.req_type == rlmts_pkg::REQ_TICK);
	assign wr_acc    = req.valid && req.ready && (req.req_type == rlmts_pkg::REQ_WRITE);
	assign out_free  = !out_valid_q || rsp.ready;
	assign out_load  = (state_q == S_EMIT) && out_free;

	assign rsp.valid          = out_valid_q;
	assign rsp.channel_select = out_ch_q;
	assign rsp.led_pattern    = out_pat_q;

	// led table
	assign tbl_we = wr_acc && ({1'b0, req.led_index} < 7'(LED_COUNT));
	assign tbl_wentry.en    = req.led_enable;
	assign tbl_wentry.color = req.led_color;

	rlmts_led_table #(
		.DEPTH (LED_COUNT)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (tbl_we),
		.waddr  (req.led_index[AW-1:0]),
		.wentry (tbl_wentry),
		.raddr  (scan_cnt_q[AW-1:0]),
		.rentry (tbl_rentry)
	);

	assign ent_bits = rlmts_pkg::colour_bits(tbl_rentry.color) & {3{tbl_rentry.en}};

	// schedule helpers
	assign pos_inc  = 3'(phase_pos_q + 3'd1);
	assign pos_next = (pos_inc >= phase_count_q || pos_inc >= 3'(rlmts_pkg::PHASE_SLOTS))
		? 3'd0 : pos_inc;

	assign bld_col = 2'(bld_q + 2'd1);
	always_comb begin
		case (bld_q)
			2'd0:    bld_dur = red_on_q;
			2'd1:    bld_dur = green_on_q;
			default: bld_dur = blue_on_q;
		endcase
	end

	always_comb begin
		mask_single = 1'b1;
		single_col  = rlmts_pkg::CH_OFF;
		case (mask_q)
			rlmts_pkg::MASK_RED:   single_col = rlmts_pkg::CH_RED;
			rlmts_pkg::MASK_GREEN: single_col = rlmts_pkg::CH_GREEN;
			rlmts_pkg::MASK_BLUE:  single_col = rlmts_pkg::CH_BLUE;
			default:               mask_single = 1'b0;
		endcase
	end

	// phase list write port
	always_comb begin
		ph_we  = 1'b0;
		ph_idx = phase_count_q;
		ph_col = rlmts_pkg::CH_OFF;
		ph_dur = gap_off_q;
		case (state_q)
			S_ADV: begin
				ph_idx = 3'd0;
				ph_col = single_col;
				ph_dur = rlmts_pkg::HOLD_DUR;
				ph_we  = (mask_q != 3'h0) && (mask_q != prev_mask_q) && mask_single;
			end
			S_BUILD: begin
				if (gap_pend_q) begin
					ph_we = phase_count_q < 3'(rlmts_pkg::PHASE_SLOTS);
				end else if (mask_q[bld_q]) begin
					ph_col = bld_col;
					ph_dur = bld_dur;
					ph_we  = phase_count_q < 3'(rlmts_pkg::PHASE_SLOTS);
				end
			end
			default: ph_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ph_we) begin
			phase_col_q[ph_idx] <= ph_col;
			phase_dur_q[ph_idx] <= ph_dur;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_on_q   <= 8'd10;
			green_on_q <= 8'd9;
			blue_on_q  <= 8'd11;
			gap_off_q  <= 8'd5;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				rlmts_pkg::REG_RED_ON:   red_on_q   <= cfg.data;
				rlmts_pkg::REG_GREEN_ON: green_on_q <= cfg.data;
				rlmts_pkg::REG_BLUE_ON:  blue_on_q  <= cfg.data;
				rlmts_pkg::REG_GAP_OFF:  gap_off_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch_q  <= cur_ch_q;
			out_pat_q <= pat_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			scan_cnt_q    <= '0;
			rd_vld_s1     <= 1'b0;
			rd_idx_s1     <= '0;
			pat_q         <= '0;
			mask_q        <= '0;
			toggle_q      <= 1'b0;
			prev_mask_q   <= '0;
			phase_count_q <= '0;
			phase_pos_q   <= '0;
			ms_rem_q      <= '0;
			cur_ch_q      <= rlmts_pkg::CH_OFF;
			bld_q         <= '0;
			gap_pend_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;

			// table read pipeline
			rd_vld_s1 <= (state_q == S_SCAN) && (scan_cnt_q < CW'(SCAN_N));
			rd_idx_s1 <= scan_cnt_q[AW-1:0];
			if (rd_vld_s1) begin
				mask_q <= mask_q | ent_bits;
				if ((rd_idx_s1 < AW'(PW))
						&& ((ent_bits & rlmts_pkg::chan_bit(cur_ch_q)) != 3'h0))
					pat_q[rd_idx_s1[4:0]] <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (tick_acc) begin
						scan_cnt_q <= '0;
						pat_q      <= '0;
						mask_q     <= '0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_cnt_q < CW'(SCAN_N)) begin
						scan_cnt_q <= CW'(scan_cnt_q + 1'b1);
					end else if (!rd_vld_s1) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						toggle_q <= !toggle_q;
						state_q  <= toggle_q ? S_ADV : S_IDLE;
					end
				end
				S_ADV: begin
					state_q <= S_IDLE;
					if (mask_q == 3'h0) begin
						prev_mask_q   <= '0;
						phase_count_q <= '0;
						phase_pos_q   <= '0;
						ms_rem_q      <= '0;
						cur_ch_q      <= rlmts_pkg::CH_OFF;
					end else if (mask_q != prev_mask_q) begin
						prev_mask_q <= mask_q;
						phase_pos_q <= '0;
						if (mask_single) begin
							phase_count_q <= 3'd1;
							state_q       <= S_FINISH;
						end else begin
							phase_count_q <= '0;
							bld_q         <= '0;
							gap_pend_q    <= 1'b0;
							state_q       <= S_BUILD;
						end
					end else if (phase_count_q == 3'd1
							&& phase_dur_q[0] == rlmts_pkg::HOLD_DUR) begin
						cur_ch_q <= phase_col_q[0];
					end else if (ms_rem_q != 8'd0) begin
						ms_rem_q <= 8'(ms_rem_q - 8'd1);
					end else begin
						phase_pos_q <= pos_next;
						cur_ch_q    <= phase_col_q[pos_next];
						ms_rem_q    <= rlmts_pkg::countdown(phase_dur_q[pos_next]);
					end
				end
				S_BUILD: begin
					if (ph_we) phase_count_q <= 3'(phase_count_q + 3'd1);
					if (!gap_pend_q && mask_q[bld_q] && gap_off_q != 8'd0) begin
						gap_pend_q <= 1'b1;
					end else begin
						gap_pend_q <= 1'b0;
						if (bld_q == 2'd2) state_q <= S_FINISH;
						else bld_q <= 2'(bld_q + 2'd1);
					end
				end
				S_FINISH: begin
					cur_ch_q <= phase_col_q[0];
					ms_rem_q <= rlmts_pkg::countdown(phase_dur_q[0]);
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_pos_in_list, (state_q == S_IDLE && phase_count_q != 3'd0), (phase_pos_q < phase_count_q), "phase position beyond phase list")
	`ASSERT_IMPL(a_count_bound, 1'b1, (phase_count_q <= 3'(rlmts_pkg::PHASE_SLOTS)), "phase list overflow")
	`ASSERT_NEXT(a_empty_off, (state_q == S_ADV && mask_q == 3'h0), (cur_ch_q == rlmts_pkg::CH_OFF), "empty mask left a channel on")
	`ASSERT_IMPL(a_scan_drained, req.ready, (!rd_vld_s1), "table read in flight while idle")

endmodule

// ===== rtl/core/rlmts_led_table.sv =====
`timescale 1ns / 1ps

module rlmts_led_table #(
	parameter int unsigned DEPTH = 24,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  rlmts_pkg::entry_t   wentry,
	input  logic [AW-1:0]       raddr,
	output rlmts_pkg::entry_t   rentry
);

	logic [DEPTH-1:0]  valid_q;
	logic              rd_valid_q;
	rlmts_pkg::entry_t mem [DEPTH];
	rlmts_pkg::entry_t rd_data_q;

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) valid_q[waddr] <= 1'b1;
			rd_valid_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wentry;
		rd_data_q <= mem[raddr];
	end

	assign rentry = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== sim/rgb_led_multiplex_tick_sequencer_tb.sv =====
`timescale 1ns / 1ps

module rgb_led_multiplex_tick_sequencer_tb;

	import rlmts_pkg::*;

	localparam int LEDS = 24;
	localparam int WIRED = 20;
	localparam logic [2:0] COL_UNUSED = 3'd7;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 48;

	typedef struct packed {
		logic [1:0]  ch;
		logic [23:0] pat;
	} frame_t;

	typedef struct packed {
		logic       typ;
		logic [5:0] idx;
		logic       en;
		logic [2:0] col;
		logic       chk;
		frame_t     frame;
	} dir_row_t;

	logic clk;
	logic arst_n;

	rlmts_req_if req_ch ();
	rlmts_rsp_if rsp_ch ();
	rlmts_cfg_if cfg_ch ();

	rgb_led_multiplex_tick_sequencer #(
		.LED_COUNT(LEDS),
		.WIRED_COUNT(WIRED)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// model copy of the block
	logic       led_on_tbl [LEDS];
	logic [2:0] led_col_tbl [LEDS];
	logic [7:0] red_ms, green_ms, blue_ms, gap_ms;
	logic       half_ms;
	logic [2:0] mask_prev;
	logic [1:0] phase_ch [PHASE_SLOTS];
	logic [7:0] phase_ms [PHASE_SLOTS];
	int         phase_n;
	int         phase_at;
	logic [7:0] ms_left;
	logic [1:0] lit_ch;

	frame_t   pending_frames [$];
	frame_t   got_frame;
	dir_row_t dir_rows [$];
	int       err_count;
	int       snd_idle_pct;
	int       rcv_idle_pct;
	bit       hold_req;

	always #6 clk = ~clk;

	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [2:0] color_mask(input logic [2:0] col);
		case (col)
			COL_RED:    return MASK_RED;
			COL_GREEN:  return MASK_GREEN;
			COL_BLUE:   return MASK_BLUE;
			COL_YELLOW: return MASK_RED | MASK_GREEN;
			COL_PURPLE: return MASK_RED | MASK_BLUE;
			COL_CYAN:   return MASK_GREEN | MASK_BLUE;
			default:    return 3'h0;
		endcase
	endfunction

	function automatic logic [23:0] lit_leds(input logic [1:0] ch);
		logic [2:0]  sel;
		logic [23:0] p;
		sel = (ch == CH_OFF) ? 3'h0 : 3'(3'h1 << (ch - 2'd1));
		p = '0;
		for (int i = 0; i < WIRED && i < 24; i++)
			if (led_on_tbl[i] && (color_mask(led_col_tbl[i]) & sel) != 3'h0)
				p[i] = 1'b1;
		return p;
	endfunction

	function automatic logic [7:0] ms_for(input logic [7:0] len);
		return (len == HOLD_DUR || len == 8'd0) ? 8'd0 : len - 8'd1;
	endfunction

	task automatic append_phase(input logic [1:0] ch, input logic [7:0] len);
		if (phase_n < PHASE_SLOTS) begin
			phase_ch[phase_n] = ch;
			phase_ms[phase_n] = len;
			phase_n++;
		end
	endtask

	task automatic predict_frame(output frame_t f);
		logic [2:0] m;
		f.ch = lit_ch;
		f.pat = lit_leds(lit_ch);
		half_ms = ~half_ms;
		if (!half_ms) begin
			m = 3'h0;
			for (int i = 0; i < WIRED; i++)
				if (led_on_tbl[i])
					m |= color_mask(led_col_tbl[i]);
			if (m == 3'h0) begin
				mask_prev = 3'h0;
				phase_n = 0;
				phase_at = 0;
				ms_left = 8'd0;
				lit_ch = CH_OFF;
			end else if (m != mask_prev) begin
				mask_prev = m;
				phase_n = 0;
				phase_at = 0;
				if (m == MASK_RED) begin
					append_phase(CH_RED, HOLD_DUR);
				end else if (m == MASK_GREEN) begin
					append_phase(CH_GREEN, HOLD_DUR);
				end else if (m == MASK_BLUE) begin
					append_phase(CH_BLUE, HOLD_DUR);
				end else begin
					if (m & MASK_RED) begin
						append_phase(CH_RED, red_ms);
						if (gap_ms != 8'd0) append_phase(CH_OFF, gap_ms);
					end
					if (m & MASK_GREEN) begin
						append_phase(CH_GREEN, green_ms);
						if (gap_ms != 8'd0) append_phase(CH_OFF, gap_ms);
					end
					if (m & MASK_BLUE) begin
						append_phase(CH_BLUE, blue_ms);
						if (gap_ms != 8'd0) append_phase(CH_OFF, gap_ms);
					end
				end
				lit_ch = phase_ch[0];
				ms_left = ms_for(phase_ms[0]);
			end else if (phase_n == 1 && phase_ms[0] == HOLD_DUR) begin
				lit_ch = phase_ch[0];
			end else if (ms_left != 8'd0) begin
				ms_left--;
			end else begin
				phase_at++;
				if (phase_at >= phase_n) phase_at = 0;
				lit_ch = phase_ch[phase_at];
				ms_left = ms_for(phase_ms[phase_at]);
			end
		end
	endtask

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_req(input logic typ, input logic [5:0] idx, input logic en,
			input logic [2:0] col, input logic chk, input frame_t fixed);
		frame_t f;
		while ($urandom_range(99) < snd_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= typ;
		req_ch.led_index <= idx;
		req_ch.led_enable <= en;
		req_ch.led_color <= col;
		do @(posedge clk); while (!req_ch.ready);
		if (typ == REQ_TICK) begin
			predict_frame(f);
			pending_frames.push_back(chk ? fixed : f);
		end else if (idx < LEDS) begin
			led_on_tbl[idx] = en;
			led_col_tbl[idx] = col;
		end
		@(negedge clk);
	endtask

	task automatic quiesce();
		req_ch.valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [7:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= r;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		case (r)
			REG_RED_ON:   red_ms = v;
			REG_GREEN_ON: green_ms = v;
			REG_BLUE_ON:  blue_ms = v;
			REG_GAP_OFF:  gap_ms = v;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [7:0] gap);
		write_reg(REG_RED_ON, r);
		write_reg(REG_GREEN_ON, g);
		write_reg(REG_BLUE_ON, b);
		write_reg(REG_GAP_OFF, gap);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_random(input int n);
		int         done_n;
		int         burst;
		int         wr_pct;
		int         palette;
		int         pick;
		logic [5:0] idx;
		logic       en;
		logic [2:0] col;
		logic [2:0] prim;
		done_n = 0;
		while (done_n < n) begin
			// repaint all wired leds, mostly from a narrow palette to reach empty and single masks
			if ($urandom_range(9) < 3) begin
				palette = $urandom_range(2);
				prim = 3'($urandom_range(COL_BLUE, COL_RED));
				for (int i = 0; i < WIRED; i++) begin
					en = 1'($urandom_range(1));
					if (palette == 0)
						col = $urandom_range(1) ? COL_OFF : COL_UNUSED;
					else if (palette == 1)
						col = $urandom_range(3) ? prim : COL_OFF;
					else
						col = 3'($urandom_range(7));
					send_req(REQ_WRITE, 6'(i), en, col, 1'b0, '0);
					done_n++;
				end
			end
			burst = $urandom_range(60, 10);
			case ($urandom_range(2))
				0: wr_pct = 2;
				1: wr_pct = 20;
				default: wr_pct = 50;
			endcase
			repeat (burst) begin
				if ($urandom_range(99) < wr_pct) begin
					pick = $urandom_range(19);
					if (pick < 14)
						idx = 6'($urandom_range(WIRED - 1));
					else if (pick < 17)
						idx = 6'($urandom_range(LEDS - 1, WIRED));
					else
						idx = 6'($urandom_range(63, LEDS));
					en = ($urandom_range(99) < 75);
					col = 3'($urandom_range(7));
					send_req(REQ_WRITE, idx, en, col, 1'b0, '0);
					if (idx < LEDS) done_n++;
				end else begin
					send_req(REQ_TICK, 6'($urandom), 1'($urandom), 3'($urandom), 1'b0, '0);
					done_n++;
				end
			end
		end
	endtask

	// receiver
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_frames.size() == 0) begin
				$error("result with none expected: channel_select %0d led_pattern %06h",
					rsp_ch.channel_select, rsp_ch.led_pattern);
				err_count++;
			end else begin
				got_frame = pending_frames.pop_front();
				if (rsp_ch.channel_select !== got_frame.ch) begin
					$error("channel_select: expected %0d, got %0d",
						got_frame.ch, rsp_ch.channel_select);
					err_count++;
				end
				if (rsp_ch.led_pattern !== got_frame.pat) begin
					$error("led_pattern: expected %06h, got %06h",
						got_frame.pat, rsp_ch.led_pattern);
					err_count++;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		err_count = 0;
		hold_req = 1'b0;
		snd_idle_pct = 12;
		rcv_idle_pct = 50;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_TICK;
		req_ch.led_index = '0;
		req_ch.led_enable = 1'b0;
		req_ch.led_color = COL_OFF;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_RED_ON;
		cfg_ch.data = '0;

		for (int i = 0; i < LEDS; i++) begin
			led_on_tbl[i] = 1'b0;
			led_col_tbl[i] = COL_OFF;
		end
		for (int i = 0; i < PHASE_SLOTS; i++) begin
			phase_ch[i] = CH_OFF;
			phase_ms[i] = 8'd0;
		end
		red_ms = 8'd10;
		green_ms = 8'd9;
		blue_ms = 8'd11;
		gap_ms = 8'd5;
		half_ms = 1'b0;
		mask_prev = 3'h0;
		phase_n = 0;
		phase_at = 0;
		ms_left = 8'd0;
		lit_ch = CH_OFF;

		dir_rows.push_back(dir_row_t'{REQ_TICK, 6'd0, 1'b0, COL_OFF, 1'b1, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_TICK, 6'd0, 1'b0, COL_OFF, 1'b1, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd0, 1'b1, COL_RED, 1'b0, {CH_OFF, 24'h0}});
		// out of range index, ignored
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd63, 1'b1, COL_UNUSED, 1'b0, {CH_OFF, 24'h0}});
		// led above the wired range
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd23, 1'b1, COL_BLUE, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_TICK, 6'd0, 1'b0, COL_OFF, 1'b1, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_TICK, 6'd0, 1'b0, COL_OFF, 1'b1, {CH_OFF, 24'h0}});
		// single red channel held
		dir_rows.push_back(dir_row_t'{REQ_TICK, 6'd0, 1'b0, COL_OFF, 1'b1, {CH_RED, 24'h1}});
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd19, 1'b1, COL_UNUSED, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd1, 1'b1, COL_YELLOW, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_TICK, 6'd0, 1'b0, COL_OFF, 1'b1, {CH_RED, 24'h3}});
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd2, 1'b1, COL_CYAN, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd3, 1'b1, COL_PURPLE, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd4, 1'b0, COL_GREEN, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd5, 1'b1, COL_GREEN, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_TICK, 6'd0, 1'b0, COL_OFF, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_TICK, 6'd63, 1'b1, COL_UNUSED, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_TICK, 6'd0, 1'b0, COL_OFF, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_TICK, 6'd0, 1'b0, COL_OFF, 1'b0, {CH_OFF, 24'h0}});
		// disable the coloured wired leds to empty the mask
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd0, 1'b0, COL_OFF, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd1, 1'b0, COL_YELLOW, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd2, 1'b0, COL_CYAN, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd3, 1'b0, COL_PURPLE, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_WRITE, 6'd5, 1'b0, COL_GREEN, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_TICK, 6'd0, 1'b0, COL_OFF, 1'b0, {CH_OFF, 24'h0}});
		dir_rows.push_back(dir_row_t'{REQ_TICK, 6'd0, 1'b0, COL_OFF, 1'b0, {CH_OFF, 24'h0}});

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_req(dir_rows[i].typ, dir_rows[i].idx, dir_rows[i].en, dir_rows[i].col,
				dir_rows[i].chk, dir_rows[i].frame);

		hold_req = 1'b1;
		run_random(230);
		quiesce();
		set_regs(8'd1, 8'd2, 8'd3, 8'd0);
		run_random(220);

		quiesce();
		snd_idle_pct = 50;
		rcv_idle_pct = 12;
		set_regs(8'd0, 8'd255, 8'd0, 8'd255);
		run_random(220);
		quiesce();
		set_regs(8'd254, 8'd254, 8'd254, 8'd254);
		hold_req = 1'b1;
		run_random(150);

		quiesce();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		set_regs(8'($urandom_range(5)), 8'($urandom_range(5)), 8'($urandom_range(5)),
			8'($urandom_range(5)));
		run_random(230);
		quiesce();
		set_regs(8'd255, 8'd1, 8'd254, 8'd0);
		hold_req = 1'b1;
		run_random(200);

		req_ch.valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
